/* rtl/core/window_impulse_detector_macros.svh */
// ----------------------------------------------------------------------------
// window impulse detector assertion macros
// shared concurrent assertion forms, clocked on clock
// ----------------------------------------------------------------------------
`ifndef WINDOW_IMPULSE_DETECTOR_MACROS_SVH
`define WINDOW_IMPULSE_DETECTOR_MACROS_SVH

// same-cycle implication, off during reset
`define WID_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("window impulse detector check failed");

// next-cycle implication, off during reset
`define WID_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("window impulse detector check failed");

// next-cycle implication that also holds across reset
`define WID_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("window impulse detector check failed");

`endif

/* rtl/core/wid_pkg.sv */
// ----------------------------------------------------------------------------
// wid_pkg
// types and fixed constants of the window impulse detector
// ----------------------------------------------------------------------------
package wid_pkg;

   // tolerance register
   localparam int unsigned TOL_W = 7;
   localparam logic [TOL_W-1:0] TOL_RESET = 7'd20;

   // percent scale and band factor width
   localparam int unsigned FAC_W = 8;
   localparam logic [FAC_W-1:0] PCT_SCALE = 8'd100;

   // request kinds carried in tuser
   localparam logic OPC_PUSH  = 1'b0;
   localparam logic OPC_CLEAR = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_BOUNDS,
      ST_CHECK,
      ST_DONE
   } wid_state_type;

   // controls fanned out to every ring cell
   typedef struct packed {
      logic shift;
      logic clear;
   } wid_cell_ctl_type;

endpackage

/* rtl/core/wid_cell.sv */
// ----------------------------------------------------------------------------
// wid_cell
// one window slot holding an x/y/z sample, shifts toward the ring head
// ----------------------------------------------------------------------------
module wid_cell
   import wid_pkg::*;
#(
   parameter int unsigned SAMPLE_BITS = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  wid_cell_ctl_type       ctl,
   input  logic [SAMPLE_BITS-1:0] in_x,
   input  logic [SAMPLE_BITS-1:0] in_y,
   input  logic [SAMPLE_BITS-1:0] in_z,
   output logic [SAMPLE_BITS-1:0] out_x,
   output logic [SAMPLE_BITS-1:0] out_y,
   output logic [SAMPLE_BITS-1:0] out_z
);

   logic [SAMPLE_BITS-1:0] x_ff;
   logic [SAMPLE_BITS-1:0] y_ff;
   logic [SAMPLE_BITS-1:0] z_ff;

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         x_ff <= '0;
         y_ff <= '0;
         z_ff <= '0;
      end else if (ctl.shift) begin
         x_ff <= in_x;
         y_ff <= in_y;
         z_ff <= in_z;
      end
   end

   assign out_x = x_ff;
   assign out_y = y_ff;
   assign out_z = z_ff;

endmodule

/* rtl/core/wid_check.sv */
// ----------------------------------------------------------------------------
// wid_check
// per-axis band test: holds scaled mean bounds, tests one sample a cycle
// ----------------------------------------------------------------------------
module wid_check
   import wid_pkg::*;
#(
   parameter int unsigned SAMPLE_BITS  = 10,
   parameter int unsigned WINDOW_DEPTH = 25,
   parameter int unsigned SUM_W        = 15
) (
   input  logic                   clock,
   input  logic                   load_bounds,
   input  logic [SUM_W-1:0]       sum,
   input  logic [TOL_W-1:0]       tol,
   input  logic [SAMPLE_BITS-1:0] sample,
   output logic                   outside
);

   localparam int unsigned PROD_W = SUM_W + FAC_W;
   localparam logic [PROD_W-1:0] SCALE = PROD_W'(WINDOW_DEPTH * 100);

   logic [FAC_W-1:0]  lo_fac;
   logic [FAC_W-1:0]  hi_fac;
   logic              lo_en_in;
   logic [PROD_W-1:0] lo_in;
   logic [PROD_W-1:0] hi_in;
   logic              lo_en_ff;
   logic [PROD_W-1:0] lo_ff;
   logic [PROD_W-1:0] hi_ff;
   logic [PROD_W-1:0] scaled;

   // above 100 percent the lower bound is negative and drops out
   always_comb begin
      lo_en_in = ({1'b0, tol} <= PCT_SCALE);
      lo_fac   = lo_en_in ? (PCT_SCALE - {1'b0, tol}) : '0;
      hi_fac   = PCT_SCALE + {1'b0, tol};
      lo_in    = PROD_W'(sum) * PROD_W'(lo_fac);
      hi_in    = PROD_W'(sum) * PROD_W'(hi_fac);
   end

   always_ff @(posedge clock) begin
      if (load_bounds) begin
         lo_en_ff <= lo_en_in;
         lo_ff    <= lo_in;
         hi_ff    <= hi_in;
      end
   end

   assign scaled  = PROD_W'(sample) * SCALE;
   assign outside = (lo_en_ff && (scaled < lo_ff)) || (scaled > hi_ff);

endmodule

/* rtl/core/window_impulse_detector.sv */
// ----------------------------------------------------------------------------
// window_impulse_detector
// sliding-window mean deviation check on three accelerometer axes
// ----------------------------------------------------------------------------
// usage
//   req channel: one word per item; tuser selects push (0) or clear (1),
//   tdata carries the x/y/z sample. a push stores the sample in the window
//   and yields one rsp word, twist_detected in bit 0. a clear empties the
//   window and yields no rsp word.
//   csr port: write tolerance_percent whenever the block is idle.
// push sequence
//   a push runs through the states in order: the window ring makes one lap
//   to update the slots and sum each axis, the bounds state loads the band
//   bounds, a second lap tests every slot against them, then the result goes
//   to the output register; no new item is accepted before the push is done.
// reset and stall
//   reset empties the window, sets tolerance to 20 percent and drops
//   rsp_tvalid. while rsp is stalled, a finished word waits in the output
//   register and the next item is still accepted; a second result then
//   waits in the done state until the output register frees up.
// ----------------------------------------------------------------------------
module window_impulse_detector
   import wid_pkg::*;
#(
   parameter int unsigned WINDOW_DEPTH = 25,
   parameter int unsigned SAMPLE_BITS  = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,  // sample_x, sample_y, sample_z
   input  logic                            req_tuser,  // opcode
   // result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,  // twist_detected
   // tolerance register
   input  logic                            csr_wr_en,
   input  logic [TOL_W-1:0]                csr_wr_data
);

   localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH);
   localparam int unsigned FILL_W = $clog2(WINDOW_DEPTH + 1);
   localparam int unsigned SUM_W  = SAMPLE_BITS + $clog2(WINDOW_DEPTH + 1);
   localparam logic [CNT_W-1:0]  LAST_IDX = CNT_W'(WINDOW_DEPTH - 1);
   localparam logic [FILL_W-1:0] FULL     = FILL_W'(WINDOW_DEPTH);

   // control state
   wid_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  wp_ff, wp_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [TOL_W-1:0]  tol_ff;

   // payload
   logic [SAMPLE_BITS-1:0] smp_x_ff, smp_y_ff, smp_z_ff;
   logic [SUM_W-1:0]       sum_x_ff, sum_y_ff, sum_z_ff;
   logic [SUM_W-1:0]       sum_x_in, sum_y_in, sum_z_in;
   logic                   flag_ff, flag_in;
   logic                   rsp_bit_ff, rsp_bit_in;

   wid_cell_ctl_type cell_ctl;
   logic             accept;
   logic             push_take;
   logic             replace;
   logic             load_bounds;
   logic             slot_free;
   logic             out_x, out_y, out_z;

   // ring taps; slot 0 is the head
   logic [SAMPLE_BITS-1:0] ring_x [WINDOW_DEPTH];
   logic [SAMPLE_BITS-1:0] ring_y [WINDOW_DEPTH];
   logic [SAMPLE_BITS-1:0] ring_z [WINDOW_DEPTH];
   logic [SAMPLE_BITS-1:0] head_x, head_y, head_z;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign push_take  = accept && (req_tuser == OPC_PUSH);
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // head slot index equals the lap counter during the update lap;
   // warm-up rewrites the whole unwritten tail, afterwards only the slot at wp
   assign replace = (state_ff == ST_UPDATE) &&
                    ((fill_ff != FULL) ? (FILL_W'(cnt_ff) >= fill_ff) : (cnt_ff == wp_ff));

   assign head_x = replace ? smp_x_ff : ring_x[0];
   assign head_y = replace ? smp_y_ff : ring_y[0];
   assign head_z = replace ? smp_z_ff : ring_z[0];

   // the ring of cells
   for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
      logic [SAMPLE_BITS-1:0] nx, ny, nz;
      if (i == WINDOW_DEPTH - 1) begin : g_tail
         assign nx = head_x;
         assign ny = head_y;
         assign nz = head_z;
      end else begin : g_body
         assign nx = ring_x[i+1];
         assign ny = ring_y[i+1];
         assign nz = ring_z[i+1];
      end
      wid_cell #(
         .SAMPLE_BITS(SAMPLE_BITS)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .ctl   (cell_ctl),
         .in_x  (nx),
         .in_y  (ny),
         .in_z  (nz),
         .out_x (ring_x[i]),
         .out_y (ring_y[i]),
         .out_z (ring_z[i])
      );
   end

   // band testers, one per axis, all looking at the head slot
   wid_check #(
      .SAMPLE_BITS(SAMPLE_BITS), .WINDOW_DEPTH(WINDOW_DEPTH), .SUM_W(SUM_W)
   ) u_check_x (
      .clock(clock), .load_bounds(load_bounds), .sum(sum_x_ff), .tol(tol_ff),
      .sample(ring_x[0]), .outside(out_x)
   );
   wid_check #(
      .SAMPLE_BITS(SAMPLE_BITS), .WINDOW_DEPTH(WINDOW_DEPTH), .SUM_W(SUM_W)
   ) u_check_y (
      .clock(clock), .load_bounds(load_bounds), .sum(sum_y_ff), .tol(tol_ff),
      .sample(ring_y[0]), .outside(out_y)
   );
   wid_check #(
      .SAMPLE_BITS(SAMPLE_BITS), .WINDOW_DEPTH(WINDOW_DEPTH), .SUM_W(SUM_W)
   ) u_check_z (
      .clock(clock), .load_bounds(load_bounds), .sum(sum_z_ff), .tol(tol_ff),
      .sample(ring_z[0]), .outside(out_z)
   );

   // sequencer
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      wp_in          = wp_ff;
      fill_in        = fill_ff;
      sum_x_in       = sum_x_ff;
      sum_y_in       = sum_y_ff;
      sum_z_in       = sum_z_ff;
      flag_in        = flag_ff;
      rsp_bit_in     = rsp_bit_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      cell_ctl.shift = 1'b0;
      cell_ctl.clear = 1'b0;
      load_bounds    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == OPC_CLEAR) begin
                  cell_ctl.clear = 1'b1;
                  wp_in          = '0;
                  fill_in        = '0;
               end else begin
                  cnt_in   = '0;
                  sum_x_in = '0;
                  sum_y_in = '0;
                  sum_z_in = '0;
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            // one lap: write new sample where due and sum the slots
            cell_ctl.shift = 1'b1;
            sum_x_in = sum_x_ff + SUM_W'(head_x);
            sum_y_in = sum_y_ff + SUM_W'(head_y);
            sum_z_in = sum_z_ff + SUM_W'(head_z);
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == LAST_IDX) begin
               cnt_in   = '0;
               wp_in    = (wp_ff == LAST_IDX) ? '0 : wp_ff + 1'b1;
               fill_in  = (fill_ff == FULL) ? FULL : fill_ff + 1'b1;
               state_in = ST_BOUNDS;
            end
         end
         ST_BOUNDS: begin
            load_bounds = 1'b1;
            flag_in     = 1'b0;
            state_in    = ST_CHECK;
         end
         ST_CHECK: begin
            // second lap: test every slot against the bounds
            cell_ctl.shift = 1'b1;
            flag_in = flag_ff || out_x || out_y || out_z;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == LAST_IDX) begin
               cnt_in   = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_bit_in   = flag_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         wp_ff        <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_wr_en) begin
         tol_ff <= csr_wr_data;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (push_take) begin
         smp_x_ff <= req_tdata[SAMPLE_BITS-1:0];
         smp_y_ff <= req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
         smp_z_ff <= req_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
      end
      sum_x_ff   <= sum_x_in;
      sum_y_ff   <= sum_y_in;
      sum_z_ff   <= sum_z_in;
      flag_ff    <= flag_in;
      rsp_bit_ff <= rsp_bit_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_bit_ff};

endmodule

/* rtl/core/wid_checker.sv */
// ----------------------------------------------------------------------------
// wid_checker
// port-level assertions for the window impulse detector, bound to the top
// ----------------------------------------------------------------------------
`include "window_impulse_detector_macros.svh"

module wid_checker
   import wid_pkg::*;
(
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [7:0]                      rsp_tdata
);

   logic push_acc;
   logic clear_acc;

   assign push_acc  = req_tvalid && req_tready && (req_tuser == OPC_PUSH);
   assign clear_acc = req_tvalid && req_tready && (req_tuser == OPC_CLEAR);

   // a reset cycle leaves no result word pending
   `WID_ASSERT_NEXT_ALWAYS(a_reset_drops_rsp, reset, !rsp_tvalid)

   // a stalled result word holds its value
   `WID_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // a push keeps the block busy for its window laps
   `WID_ASSERT_NEXT(a_push_busy, push_acc, !req_tready)

   // a clear never produces a result word
   `WID_ASSERT_NEXT(a_clear_silent, clear_acc && !rsp_tvalid, !rsp_tvalid)

   // only the flag bit of the result word is ever set
   `WID_ASSERT_NOW(a_rsp_pad, rsp_tvalid, rsp_tdata[7:1] == 7'd0)

endmodule

bind window_impulse_detector wid_checker u_wid_checker (.*);
